// File: sv/rrct_pkg.sv
// shared types and constants of the range read cache tag engine
package rrct_pkg;

  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int POS_W    = 20;
  localparam int BYTES_W  = 21;
  localparam int LEN_W    = 32;
  localparam int SUSE_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  localparam logic [BYTES_W-1:0] CHUNK_LIMIT       = 21'd1048576;
  localparam logic [SUSE_W-1:0]  SLOTS_IN_USE_RST  = 5'd16;
  localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST   = 21'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 1'b1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_FILL   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_BYPASS = 3'd2,
    ST_FILL   = 3'd3,
    ST_EOF    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HITCALC,
    S_MISS,
    S_PUT
  } state_t;

endpackage

// File: sv/rrct_if.sv
// valid/ready channels for request items and result items
interface rrct_req_if #(
  parameter int OFFSET_BITS = 48
);
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [OFFSET_BITS-1:0]           offset;
  logic [rrct_pkg::LEN_W-1:0]       length;
  logic [rrct_pkg::SLOT_W-1:0]      fill_slot;
  logic [rrct_pkg::BYTES_W-1:0]     fill_size;
  logic                             fill_eof;

  modport source (output valid, action, offset, length, fill_slot, fill_size, fill_eof,
                  input ready);
  modport sink (input valid, action, offset, length, fill_slot, fill_size, fill_eof,
                output ready);
endinterface

interface rrct_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rrct_pkg::STATUS_W-1:0]    status;
  logic [rrct_pkg::SLOT_W-1:0]      slot_index;
  logic [rrct_pkg::POS_W-1:0]       chunk_position;
  logic [rrct_pkg::BYTES_W-1:0]     hit_bytes;

  modport source (output valid, status, slot_index, chunk_position, hit_bytes,
                  input ready);
  modport sink (input valid, status, slot_index, chunk_position, hit_bytes,
                output ready);
endinterface

// File: sv/range_read_cache_tags.sv
// tag and round-robin replacement engine of a fully associative read cache
// Each slot's start offset and byte count sit in one tag memory with a registered
// read; a flip-flop live bit per slot marks occupied slots, so reset frees all
// slots at once. One item is handled at a time. Fills and bypassed lookups pass
// through the result register into the output register once that is free. A
// lookup walks the slots in index order through the single read port, one slot per
// cycle: a hit passes through the hit calculation state, while a miss waits for
// the bit-serial remainder unit, started at acceptance, that computes the victim
// pointer advance. The next item is accepted as soon as the previous result sits
// in the output register.
module range_read_cache_tags #(
  parameter int MAX_SLOTS   = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rrct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrct_pkg::CFG_DATA_W-1:0]  cfg_data,
  rrct_req_if.sink                         item,
  rrct_rsp_if.source                       result
);

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW      = IDX_W + 1;
  localparam int CW      = $clog2(NW + 1);
  localparam int ENTRY_W = OFFSET_BITS + rrct_pkg::BYTES_W;

  // configuration
  logic [rrct_pkg::SUSE_W-1:0]  slots_in_use;
  logic [rrct_pkg::BYTES_W-1:0] chunk_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= rrct_pkg::SLOTS_IN_USE_RST;
      chunk_bytes  <= rrct_pkg::CHUNK_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rrct_pkg::CFG_SLOTS_IN_USE: slots_in_use <= cfg_data[rrct_pkg::SUSE_W-1:0];
        rrct_pkg::CFG_CHUNK_BYTES:  chunk_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // state and datapath registers
  rrct_pkg::state_t state, state_next;

  logic [ENTRY_W-1:0]            tag_mem [MAX_SLOTS];
  logic [ENTRY_W-1:0]            rd_data;
  logic [MAX_SLOTS-1:0]          slot_live;
  logic [IDX_W-1:0]              victim_pointer;

  logic [OFFSET_BITS-1:0]        off_q;
  logic [rrct_pkg::LEN_W-1:0]    len_q;
  logic [NW-1:0]                 n_q;
  logic [NW-1:0]                 scan_idx;
  logic [IDX_W-1:0]              cmp_idx;
  logic                          cmp_live;

  logic [IDX_W-1:0]              hit_idx;
  logic [rrct_pkg::POS_W-1:0]    hit_pos;
  logic [rrct_pkg::BYTES_W-1:0]  hit_cnt;

  logic [NW-1:0]                 mod_rem;
  logic [NW-1:0]                 mod_dvd;
  logic [CW-1:0]                 mod_cnt;

  logic [rrct_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [rrct_pkg::SLOT_W-1:0]   res_slot, res_slot_next;
  logic [rrct_pkg::POS_W-1:0]    res_pos, res_pos_next;
  logic [rrct_pkg::BYTES_W-1:0]  res_bytes, res_bytes_next;
  logic                          res_load;

  logic                          out_valid;
  logic [rrct_pkg::STATUS_W-1:0] out_status;
  logic [rrct_pkg::SLOT_W-1:0]   out_slot;
  logic [rrct_pkg::POS_W-1:0]    out_pos;
  logic [rrct_pkg::BYTES_W-1:0]  out_bytes;

  // combinational helpers
  logic                          accept;
  logic                          out_free;
  logic                          is_bypass;
  logic                          fill_in_range;
  logic [rrct_pkg::BYTES_W-1:0]  fill_sat;
  logic [rrct_pkg::BYTES_W-1:0]  fill_cap;
  logic [NW-1:0]                 n_eff;
  logic                          issue;
  logic                          mod_busy;
  logic                          mem_we;
  logic [OFFSET_BITS-1:0]        rd_start;
  logic [rrct_pkg::BYTES_W-1:0]  rd_cnt;
  logic [OFFSET_BITS:0]          diff;
  logic                          hit;
  logic [rrct_pkg::BYTES_W-1:0]  left;
  logic [rrct_pkg::BYTES_W-1:0]  hit_serve;
  logic [NW:0]                   mod_trial;

  assign accept    = item.valid && item.ready;
  assign out_free  = !out_valid || result.ready;
  assign is_bypass = 32'(item.length) > 32'(chunk_bytes);
  assign fill_in_range = 32'(item.fill_slot) < 32'(MAX_SLOTS);
  assign issue     = scan_idx < n_q;
  assign mod_busy  = mod_cnt != '0;

  always_comb begin
    if (slots_in_use == '0) begin
      n_eff = NW'(1);
    end else if (32'(slots_in_use) > 32'(MAX_SLOTS)) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(slots_in_use);
    end
  end

  // saturate the fill size at the chunk size and at the hard limit
  always_comb begin
    fill_cap = (item.fill_size > chunk_bytes) ? chunk_bytes : item.fill_size;
    fill_sat = (fill_cap > rrct_pkg::CHUNK_LIMIT) ? rrct_pkg::CHUNK_LIMIT : fill_cap;
  end

  assign mem_we = accept && (item.action == rrct_pkg::ACT_FILL) && !item.fill_eof
                  && fill_in_range;

  // range compare of the slot read last cycle
  assign rd_start = rd_data[ENTRY_W-1:rrct_pkg::BYTES_W];
  assign rd_cnt   = rd_data[rrct_pkg::BYTES_W-1:0];
  assign diff     = {1'b0, off_q} - {1'b0, rd_start};
  assign hit      = cmp_live && slot_live[cmp_idx] && (rd_cnt != '0) && !diff[OFFSET_BITS]
                    && (diff[OFFSET_BITS-1:0] < OFFSET_BITS'(rd_cnt));

  assign left      = hit_cnt - rrct_pkg::BYTES_W'(hit_pos);
  assign hit_serve = (32'(left) < len_q) ? left : len_q[rrct_pkg::BYTES_W-1:0];

  assign mod_trial = {mod_rem, mod_dvd[NW-1]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rrct_pkg::S_IDLE: begin
        if (accept) begin
          if (item.action == rrct_pkg::ACT_FILL || is_bypass) begin
            state_next = rrct_pkg::S_PUT;
          end else begin
            state_next = rrct_pkg::S_SCAN;
          end
        end
      end
      rrct_pkg::S_SCAN: begin
        if (hit) begin
          state_next = rrct_pkg::S_HITCALC;
        end else if (!issue && cmp_live) begin
          state_next = rrct_pkg::S_MISS;
        end
      end
      rrct_pkg::S_HITCALC: state_next = rrct_pkg::S_PUT;
      rrct_pkg::S_MISS: begin
        if (!mod_busy) begin
          state_next = rrct_pkg::S_PUT;
        end
      end
      rrct_pkg::S_PUT: begin
        if (out_free) begin
          state_next = rrct_pkg::S_IDLE;
        end
      end
      default: state_next = rrct_pkg::S_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    res_load        = 1'b0;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_pos_next    = res_pos;
    res_bytes_next  = res_bytes;
    case (state)
      rrct_pkg::S_IDLE: begin
        if (accept) begin
          res_load       = 1'b1;
          res_slot_next  = item.fill_slot;
          res_pos_next   = '0;
          res_bytes_next = '0;
          if (item.action == rrct_pkg::ACT_LOOKUP) begin
            res_status_next = rrct_pkg::ST_BYPASS;
            res_slot_next   = '0;
          end else if (item.fill_eof) begin
            res_status_next = rrct_pkg::ST_EOF;
          end else begin
            res_status_next = rrct_pkg::ST_FILL;
            if (fill_in_range) begin
              res_bytes_next = fill_sat;
            end
          end
        end
      end
      rrct_pkg::S_HITCALC: begin
        res_load        = 1'b1;
        res_status_next = rrct_pkg::ST_HIT;
        res_slot_next   = rrct_pkg::SLOT_W'(hit_idx);
        res_pos_next    = hit_pos;
        res_bytes_next  = hit_serve;
      end
      rrct_pkg::S_MISS: begin
        res_load        = !mod_busy;
        res_status_next = rrct_pkg::ST_MISS;
        res_slot_next   = rrct_pkg::SLOT_W'(mod_rem);
        res_pos_next    = '0;
        res_bytes_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rrct_pkg::S_IDLE;
      slot_live      <= '0;
      victim_pointer <= '0;
      cmp_live       <= 1'b0;
      mod_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (mem_we) begin
        slot_live[IDX_W'(item.fill_slot)] <= fill_sat != '0;
      end

      cmp_live <= (state == rrct_pkg::S_SCAN) && issue && !hit;

      // bit-serial remainder for the victim pointer advance
      if (accept && item.action == rrct_pkg::ACT_LOOKUP && !is_bypass) begin
        mod_cnt <= CW'(NW);
      end else if (mod_busy) begin
        mod_cnt <= mod_cnt - CW'(1);
      end

      if (state == rrct_pkg::S_MISS && !mod_busy) begin
        victim_pointer <= mod_rem[IDX_W-1:0];
      end

      if (state == rrct_pkg::S_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[IDX_W'(item.fill_slot)] <= {item.offset, fill_sat};
    end
    rd_data <= tag_mem[scan_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      off_q    <= item.offset;
      len_q    <= item.length;
      n_q      <= n_eff;
      scan_idx <= '0;
      mod_rem  <= '0;
      mod_dvd  <= NW'(victim_pointer) + NW'(1);
    end else begin
      if (state == rrct_pkg::S_SCAN && issue) begin
        scan_idx <= scan_idx + NW'(1);
      end
      if (mod_busy) begin
        if (mod_trial >= {1'b0, n_q}) begin
          mod_rem <= NW'(mod_trial - {1'b0, n_q});
        end else begin
          mod_rem <= NW'(mod_trial);
        end
        mod_dvd <= mod_dvd << 1;
      end
    end
    cmp_idx <= scan_idx[IDX_W-1:0];
    if (hit) begin
      hit_idx <= cmp_idx;
      hit_pos <= diff[rrct_pkg::POS_W-1:0];
      hit_cnt <= rd_cnt;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_pos    <= res_pos_next;
      res_bytes  <= res_bytes_next;
    end
    if (state == rrct_pkg::S_PUT && out_free) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_pos    <= res_pos;
      out_bytes  <= res_bytes;
    end
  end

  assign item.ready            = state == rrct_pkg::S_IDLE;
  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.slot_index     = out_slot;
  assign result.chunk_position = out_pos;
  assign result.hit_bytes      = out_bytes;

endmodule
